// ===== design/ipv4rx_pkg.sv =====
// Package with the shared types, constants and helpers of the IPv4 receive header validator.
package ipv4rx_pkg;

    // Verdict codes reported with each packet.
    localparam logic [3:0] V_UDP       = 4'd0;
    localparam logic [3:0] V_TCP       = 4'd1;
    localparam logic [3:0] V_ICMP      = 4'd2;
    localparam logic [3:0] V_TOO_SMALL = 4'd3;
    localparam logic [3:0] V_VERSION   = 4'd4;
    localparam logic [3:0] V_FRAGMENT  = 4'd5;
    localparam logic [3:0] V_LENGTH    = 4'd6;
    localparam logic [3:0] V_IHL       = 4'd7;
    localparam logic [3:0] V_NOT_OURS  = 4'd8;
    localparam logic [3:0] V_TTL       = 4'd9;
    localparam logic [3:0] V_CHECKSUM  = 4'd10;
    localparam logic [3:0] V_UNKNOWN   = 4'd11;

    // Protocol numbers that are dispatched.
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Header word positions, counted in 16-bit words from the start of the header.
    localparam logic [4:0] W_VER_IHL   = 5'd0;
    localparam logic [4:0] W_TOT_LEN   = 5'd1;
    localparam logic [4:0] W_FRAG      = 5'd3;
    localparam logic [4:0] W_TTL_PROTO = 5'd4;
    localparam logic [4:0] W_DST_HI    = 5'd8;
    localparam logic [4:0] W_DST_LO    = 5'd9;

    localparam logic [15:0] MIN_FRAME_BYTES = 16'd20;
    localparam logic [3:0]  MIN_IHL         = 4'd5;
    localparam logic [3:0]  IP_VERSION      = 4'd4;
    localparam logic [7:0]  TTL_EXPIRING    = 8'd1;
    localparam logic [15:0] SUM_GOOD        = 16'hffff;
    localparam logic [31:0] ADDR_BCAST      = 32'hffff_ffff;
    localparam logic [31:0] ADDR_ZERO       = 32'h0000_0000;
    // Last word index for a header whose IHL is below the minimum.
    localparam logic [4:0]  LAST_SHORT      = 5'd9;

    // Classified packet: raw check flags plus the reported fields.
    typedef struct packed {
        logic       too_small;
        logic       ver_bad;
        logic       frag_bad;
        logic       len_bad;
        logic       ihl_bad;
        logic       dest_bad;
        logic       ttl_one;
        logic       sum_bad;
        logic [7:0]  proto;
        logic [15:0] total_length;
        logic [5:0]  header_bytes;
    } t_chk;

    // Queue status seen by the neighbors of the queue.
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    // Ones-complement add with end-around carry.
    function automatic logic [15:0] f_ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== design/ipv4rx_front.sv =====
// Front end: tracks header words, runs the checksum and captures the checked fields.
module ipv4rx_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [15:0]         i_word,
    input  logic                i_start,
    input  logic [15:0]         i_frame_bytes,
    input  logic [31:0]         i_local_addr,
    output logic                o_push,
    output ipv4rx_pkg::t_chk    o_rec
);

    logic [4:0]  r_word_index;
    logic [15:0] r_sum;
    logic [3:0]  r_ihl;
    logic [3:0]  r_ver;
    logic [15:0] r_len;
    logic [15:0] r_avail;
    logic        r_frag;
    logic        r_ttl1;
    logic [7:0]  r_proto;
    logic [15:0] r_dest_hi;
    logic        r_dest_bad;
    logic        r_done;

    logic [4:0]  n_word_index;
    logic [15:0] n_sum;
    logic [3:0]  n_ihl;
    logic [3:0]  n_ver;
    logic [15:0] n_len;
    logic [15:0] n_avail;
    logic        n_frag;
    logic        n_ttl1;
    logic [7:0]  n_proto;
    logic [15:0] n_dest_hi;
    logic        n_dest_bad;

    logic        short_frame;
    logic        active;
    logic        is_last;
    logic [4:0]  idx;
    logic [4:0]  last_idx;
    logic [4:0]  hdr_words;
    logic [31:0] dest;

    always_comb begin
        short_frame = i_start && (i_frame_bytes < ipv4rx_pkg::MIN_FRAME_BYTES);
        active      = i_start ? !short_frame : !r_done;
        idx         = i_start ? 5'd0 : r_word_index;

        // A start word drops whatever the previous packet left behind.
        n_sum      = i_start ? 16'd0 : r_sum;
        n_ihl      = i_start ? 4'd0 : r_ihl;
        n_ver      = i_start ? 4'd0 : r_ver;
        n_len      = i_start ? 16'd0 : r_len;
        n_avail    = i_start ? i_frame_bytes : r_avail;
        n_frag     = i_start ? 1'b0 : r_frag;
        n_ttl1     = i_start ? 1'b0 : r_ttl1;
        n_proto    = i_start ? 8'd0 : r_proto;
        n_dest_hi  = i_start ? 16'd0 : r_dest_hi;
        n_dest_bad = i_start ? 1'b0 : r_dest_bad;
        dest       = {n_dest_hi, i_word};

        case (idx)
            ipv4rx_pkg::W_VER_IHL: begin
                n_ver = i_word[15:12];
                n_ihl = i_word[11:8];
            end
            ipv4rx_pkg::W_TOT_LEN: begin
                n_len = i_word;
            end
            ipv4rx_pkg::W_FRAG: begin
                n_frag = (i_word[13:0] != 14'd0);
            end
            ipv4rx_pkg::W_TTL_PROTO: begin
                n_ttl1  = (i_word[15:8] == ipv4rx_pkg::TTL_EXPIRING);
                n_proto = i_word[7:0];
            end
            ipv4rx_pkg::W_DST_HI: begin
                n_dest_hi = i_word;
            end
            ipv4rx_pkg::W_DST_LO: begin
                n_dest_bad = (dest != i_local_addr) && (dest != ipv4rx_pkg::ADDR_BCAST)
                             && (dest != ipv4rx_pkg::ADDR_ZERO);
            end
            default: begin
            end
        endcase

        hdr_words = {n_ihl, 1'b0};
        if (idx < hdr_words) begin
            n_sum = ipv4rx_pkg::f_ones_add(n_sum, i_word);
        end

        last_idx     = (n_ihl < ipv4rx_pkg::MIN_IHL) ? ipv4rx_pkg::LAST_SHORT
                                                     : hdr_words - 5'd1;
        is_last      = active && (idx == last_idx);
        n_word_index = idx + 5'd1;
    end

    always_comb begin
        o_push = i_acc && (short_frame || is_last);
        o_rec  = '0;
        if (short_frame) begin
            o_rec.too_small = 1'b1;
        end else begin
            o_rec.ver_bad      = (n_ver != ipv4rx_pkg::IP_VERSION);
            o_rec.frag_bad     = n_frag;
            o_rec.len_bad      = (n_len > n_avail);
            o_rec.ihl_bad      = (n_ihl < ipv4rx_pkg::MIN_IHL);
            o_rec.dest_bad     = n_dest_bad;
            o_rec.ttl_one      = n_ttl1;
            o_rec.sum_bad      = (n_sum != ipv4rx_pkg::SUM_GOOD);
            o_rec.proto        = n_proto;
            o_rec.total_length = n_len;
            o_rec.header_bytes = {n_ihl, 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index <= '0;
            r_sum        <= '0;
            r_ihl        <= '0;
            r_ver        <= '0;
            r_len        <= '0;
            r_avail      <= '0;
            r_frag       <= 1'b0;
            r_ttl1       <= 1'b0;
            r_proto      <= '0;
            r_dest_hi    <= '0;
            r_dest_bad   <= 1'b0;
            r_done       <= 1'b1;
        end else if (i_acc) begin
            if (short_frame) begin
                r_done <= 1'b1;
            end else if (active) begin
                r_word_index <= n_word_index;
                r_sum        <= n_sum;
                r_ihl        <= n_ihl;
                r_ver        <= n_ver;
                r_len        <= n_len;
                r_avail      <= n_avail;
                r_frag       <= n_frag;
                r_ttl1       <= n_ttl1;
                r_proto      <= n_proto;
                r_dest_hi    <= n_dest_hi;
                r_dest_bad   <= n_dest_bad;
                r_done       <= is_last;
            end
        end
    end

endmodule

// ===== design/ipv4rx_fifo.sv =====
// Short queue of classified packets between the front end and the output stage.
module ipv4rx_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 38
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output ipv4rx_pkg::t_q_stat  o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        o_stat.valid = (r_cnt != '0);
        o_stat.full  = (r_cnt == CW'(DEPTH));
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && o_stat.valid;
        n_wr         = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd         = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        o_data       = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/ipv4rx_back.sv =====
// Back end: turns check flags into a verdict and holds the result for the output stream.
module ipv4rx_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipv4rx_pkg::t_q_stat  i_q_stat,
    input  ipv4rx_pkg::t_chk     i_rec,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [39:0]          o_data
);

    logic        r_valid;
    logic [39:0] r_data;
    logic [3:0]  verdict;
    logic        load;

    // First failing check wins; a clean header is dispatched by protocol.
    always_comb begin
        if (i_rec.too_small) begin
            verdict = ipv4rx_pkg::V_TOO_SMALL;
        end else if (i_rec.ver_bad) begin
            verdict = ipv4rx_pkg::V_VERSION;
        end else if (i_rec.frag_bad) begin
            verdict = ipv4rx_pkg::V_FRAGMENT;
        end else if (i_rec.len_bad) begin
            verdict = ipv4rx_pkg::V_LENGTH;
        end else if (i_rec.ihl_bad) begin
            verdict = ipv4rx_pkg::V_IHL;
        end else if (i_rec.dest_bad) begin
            verdict = ipv4rx_pkg::V_NOT_OURS;
        end else if (i_rec.ttl_one) begin
            verdict = ipv4rx_pkg::V_TTL;
        end else if (i_rec.sum_bad) begin
            verdict = ipv4rx_pkg::V_CHECKSUM;
        end else if (i_rec.proto == ipv4rx_pkg::PROTO_UDP) begin
            verdict = ipv4rx_pkg::V_UDP;
        end else if (i_rec.proto == ipv4rx_pkg::PROTO_TCP) begin
            verdict = ipv4rx_pkg::V_TCP;
        end else if (i_rec.proto == ipv4rx_pkg::PROTO_ICMP) begin
            verdict = ipv4rx_pkg::V_ICMP;
        end else begin
            verdict = ipv4rx_pkg::V_UNKNOWN;
        end
        load    = i_q_stat.valid && (!r_valid || i_ready);
        o_pop   = load;
        o_valid = r_valid;
        o_data  = r_data;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= {6'd0, i_rec.header_bytes, i_rec.total_length, i_rec.proto, verdict};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== design/ipv4_rx_header_validator.sv =====
// Top level of the IPv4 receive header validator: ports, register, front, queue and back.
//
// Usage. Header words enter on the s_axis stream, one 16-bit word per request, in wire
// order. tuser marks the first word of a packet, and that request also carries the byte
// count from the IPv4 header to the frame end in the upper half of tdata. One result per
// packet leaves on the m_axis stream: verdict, protocol, total length and header bytes.
// A start word with fewer than 20 frame bytes yields a "too small" result at once;
// otherwise the result follows word max(10, 2*IHL) of the header. Words outside a packet
// are dropped, and a start word in mid-packet abandons the packet in progress.
// Throughput is one word per clock while the queue has room. A result enters the queue
// when its last word is accepted and then moves into the output register, which drives
// m_axis tvalid, once that register is free. The front end checks each word in the cycle
// it arrives; the queue of QUEUE_DEPTH entries plus the output register absorb a stalled
// receiver, and tready falls only when the queue is full. Reset is synchronous: the block
// is idle until a start word, the queue and output are empty, and local_address is zero.
// The APB port writes local_address at byte address 0; it must only be written while the
// block is idle.
module ipv4_rx_header_validator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] header_word, [31:16] frame_bytes
    input  logic        i_s_axis_tuser,   // [0] start_req
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [3:0] verdict, [11:4] protocol, [27:12] total_length, [33:28] header_bytes, rest zero
    output logic [39:0] o_m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int REC_W = $bits(ipv4rx_pkg::t_chk);

    logic [31:0]          r_local_addr;
    logic                 w_acc;
    logic                 w_push;
    logic                 w_pop;
    ipv4rx_pkg::t_chk     w_rec_in;
    ipv4rx_pkg::t_chk     w_rec_out;
    logic [REC_W-1:0]     w_q_data;
    ipv4rx_pkg::t_q_stat  w_q_stat;

    // The register file holds a single register; the low address bits are ignored.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : r_local_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_local_addr <= pwdata;
        end
    end

    // A word is taken only when the queue has room for the result it might finish.
    assign o_s_axis_tready = !w_q_stat.full;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    ipv4rx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (w_acc),
        .i_word        (i_s_axis_tdata[15:0]),
        .i_start       (i_s_axis_tuser),
        .i_frame_bytes (i_s_axis_tdata[31:16]),
        .i_local_addr  (r_local_addr),
        .o_push        (w_push),
        .o_rec         (w_rec_in)
    );

    ipv4rx_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (REC_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rec_in),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    assign w_rec_out = w_q_data;

    ipv4rx_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_rec    (w_rec_out),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // A finished packet never meets a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("result pushed into a full queue");

    // An undersized start word is answered in the same request.
    a_small_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_axis_tuser && (i_s_axis_tdata[31:16] < ipv4rx_pkg::MIN_FRAME_BYTES))
        |-> w_push)
        else $error("too-small frame produced no result");

    // A queued result is held either in the queue or in the output register.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (w_q_stat.valid || o_m_axis_tvalid))
        else $error("result lost between queue and output");
`endif

endmodule

// ===== dv/ipv4_rx_verdict_checker.sv =====
// Checker that predicts the verdict of each IPv4 header and compares it with the results.
module ipv4_rx_verdict_checker #(
    parameter logic [2:0] LOCAL_ADDR_REG = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_pending,
    output int          o_fail_count
);

    typedef struct packed {
        logic [3:0]  verdict;
        logic [7:0]  proto;
        logic [15:0] total_length;
        logic [5:0]  header_bytes;
    } t_verdict;

    t_verdict    verdict_q[$];
    logic [31:0] local_addr;
    logic [4:0]  word_idx;
    logic [15:0] hdr_sum;
    logic [3:0]  ihl_seen;
    logic [3:0]  ver_seen;
    logic [15:0] len_seen;
    logic [15:0] frame_avail;
    logic        frag_seen;
    logic        ttl_expiring;
    logic [7:0]  proto_seen;
    logic [15:0] dest_hi_seen;
    logic        dest_reject;
    logic        waiting_start;
    int          mismatch_cnt = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    // End-around-carry addition of two 16-bit words.
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[15:0] + {15'd0, wide[16]};
    endfunction

    task automatic clear_header();
        word_idx     = '0;
        hdr_sum      = '0;
        ihl_seen     = '0;
        ver_seen     = '0;
        len_seen     = '0;
        frame_avail  = '0;
        frag_seen    = 1'b0;
        ttl_expiring = 1'b0;
        proto_seen   = '0;
        dest_hi_seen = '0;
        dest_reject  = 1'b0;
    endtask

    // Advance the header state by one accepted word and queue the verdict if one is due.
    task automatic classify_word(input logic [15:0] w, input logic st, input logic [15:0] fb);
        logic [31:0] dest;
        logic [4:0]  last_idx;
        t_verdict    v;
        if (st) begin
            clear_header();
            if (fb < ipv4rx_pkg::MIN_FRAME_BYTES) begin
                waiting_start = 1'b1;
                v = '{ipv4rx_pkg::V_TOO_SMALL, 8'd0, 16'd0, 6'd0};
                verdict_q.push_back(v);
                return;
            end
            frame_avail   = fb;
            waiting_start = 1'b0;
        end else if (waiting_start) begin
            return;
        end

        case (word_idx)
            ipv4rx_pkg::W_VER_IHL: begin
                ver_seen = w[15:12];
                ihl_seen = w[11:8];
            end
            ipv4rx_pkg::W_TOT_LEN:   len_seen = w;
            ipv4rx_pkg::W_FRAG:      frag_seen = (w[13:0] != 14'd0);
            ipv4rx_pkg::W_TTL_PROTO: begin
                ttl_expiring = (w[15:8] == ipv4rx_pkg::TTL_EXPIRING);
                proto_seen   = w[7:0];
            end
            ipv4rx_pkg::W_DST_HI:    dest_hi_seen = w;
            ipv4rx_pkg::W_DST_LO: begin
                dest = {dest_hi_seen, w};
                dest_reject = dest != local_addr && dest != ipv4rx_pkg::ADDR_BCAST
                              && dest != ipv4rx_pkg::ADDR_ZERO;
            end
            default: ;
        endcase

        if (word_idx < {ihl_seen, 1'b0})
            hdr_sum = fold_add(hdr_sum, w);

        last_idx = (ihl_seen < ipv4rx_pkg::MIN_IHL) ? ipv4rx_pkg::LAST_SHORT
                                                    : {ihl_seen, 1'b0} - 5'd1;
        if (word_idx != last_idx) begin
            word_idx = word_idx + 5'd1;
            return;
        end

        if (ver_seen != ipv4rx_pkg::IP_VERSION)
            v.verdict = ipv4rx_pkg::V_VERSION;
        else if (frag_seen)
            v.verdict = ipv4rx_pkg::V_FRAGMENT;
        else if (len_seen > frame_avail)
            v.verdict = ipv4rx_pkg::V_LENGTH;
        else if (ihl_seen < ipv4rx_pkg::MIN_IHL)
            v.verdict = ipv4rx_pkg::V_IHL;
        else if (dest_reject)
            v.verdict = ipv4rx_pkg::V_NOT_OURS;
        else if (ttl_expiring)
            v.verdict = ipv4rx_pkg::V_TTL;
        else if (hdr_sum != ipv4rx_pkg::SUM_GOOD)
            v.verdict = ipv4rx_pkg::V_CHECKSUM;
        else begin
            case (proto_seen)
                ipv4rx_pkg::PROTO_UDP:  v.verdict = ipv4rx_pkg::V_UDP;
                ipv4rx_pkg::PROTO_TCP:  v.verdict = ipv4rx_pkg::V_TCP;
                ipv4rx_pkg::PROTO_ICMP: v.verdict = ipv4rx_pkg::V_ICMP;
                default:                v.verdict = ipv4rx_pkg::V_UNKNOWN;
            endcase
        end
        v.proto        = proto_seen;
        v.total_length = len_seen;
        v.header_bytes = {ihl_seen, 2'b00};
        waiting_start  = 1'b1;
        verdict_q.push_back(v);
    endtask

    task automatic flag_mismatch(input string what, input logic [39:0] exp_v,
                                 input logic [39:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch at %0t: %s expected %0h got %0h", $time, what, exp_v, act_v);
    endtask

    task automatic check_result(input logic [39:0] d);
        t_verdict e;
        if (verdict_q.size() == 0) begin
            flag_mismatch("result with nothing expected", 40'd0, d);
            return;
        end
        e = verdict_q.pop_front();
        if (d[3:0] != e.verdict)
            flag_mismatch("verdict", 40'(e.verdict), 40'(d[3:0]));
        if (d[11:4] != e.proto)
            flag_mismatch("protocol", 40'(e.proto), 40'(d[11:4]));
        if (d[27:12] != e.total_length)
            flag_mismatch("total_length", 40'(e.total_length), 40'(d[27:12]));
        if (d[33:28] != e.header_bytes)
            flag_mismatch("header_bytes", 40'(e.header_bytes), 40'(d[33:28]));
        if (d[39:34] != 6'd0)
            flag_mismatch("tdata padding", 40'd0, 40'(d[39:34]));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            local_addr    = ipv4rx_pkg::ADDR_ZERO;
            waiting_start = 1'b1;
            clear_header();
            verdict_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == LOCAL_ADDR_REG) begin
                if (i_pwrite)
                    local_addr = i_pwdata;
                else if (i_prdata != local_addr)
                    flag_mismatch("local_address readback", 40'(local_addr), 40'(i_prdata));
            end
            if (i_s_tvalid && i_s_tready)
                classify_word(i_s_tdata[15:0], i_s_tuser, i_s_tdata[31:16]);
            if (i_m_tvalid && i_m_tready)
                check_result(i_m_tdata);
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

// ===== dv/tb_ipv4_rx_header_validator.sv =====
// Testbench top for the IPv4 receive header validator: clock, reset, header stimulus and verdict.
module tb_ipv4_rx_header_validator;

    // Byte address of the local_address register on the APB port.
    localparam logic [2:0] LOCAL_ADDR_REG = 3'd0;
    // The header checksum sits in word 5; the generator fills it in.
    localparam int CSUM_WORD      = 5;
    localparam int MAX_WORDS      = 30;
    localparam int PKTS_PER_PHASE = 3;
    localparam int DRAIN_CYCLES   = 4;

    // Description of one generated header. A nonzero cut sends only that many
    // words, so the next start word abandons the packet in mid-flight.
    typedef struct {
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] tot_len;
        logic [15:0] frame_bytes;
        logic [15:0] frag;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] dest;
        logic        bad_sum;
        int          cut;
    } t_hdr;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    int          pending;
    int          fail_count;

    // Idle and stall rates in percent, changed per phase by the stimulus.
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    // The address last written, used to aim generated headers at the block.
    logic [31:0] local_cur      = '0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ipv4_rx_header_validator DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // The checker watches both streams and the APB port, predicts every verdict
    // and reports how many results are still outstanding and how many mismatched.
    ipv4_rx_verdict_checker #(
        .LOCAL_ADDR_REG (LOCAL_ADDR_REG)
    ) verdict_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // The result side stalls at random; one assignment per edge keeps it race free.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop in case a request or a result never completes.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Offer one header word and return at the edge where the request is taken.
    // The sender may sit idle for a while first, depending on the phase.
    task automatic send_word(input logic [15:0] w, input logic st, input logic [15:0] fb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fb, w};
        s_tuser  <= st;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted verdict has been seen, then wait out
    // the DRAIN_CYCLES pause so that a half-finished header has settled too.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write local_address and read it straight back; psel stays high between
    // the two transfers so that no signal is assigned twice in one step.
    task automatic write_local(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LOCAL_ADDR_REG;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        local_cur  = v;
    endtask

    // A well-formed UDP header aimed at the block, with a frame that holds the
    // whole packet plus some trailing padding.
    function automatic t_hdr base_hdr(input int tot);
        t_hdr h;
        int   fr;
        fr = tot + int'($urandom_range(46));
        if (fr > 65535 || $urandom_range(7) == 0)
            fr = 65535;
        h.ver         = ipv4rx_pkg::IP_VERSION;
        h.ihl         = ipv4rx_pkg::MIN_IHL;
        h.tot_len     = 16'(tot);
        h.frame_bytes = 16'(fr);
        h.frag        = 16'h0000;
        h.ttl         = 8'($urandom_range(2, 255));
        h.proto       = ipv4rx_pkg::PROTO_UDP;
        h.dest        = local_cur;
        h.bad_sum     = 1'b0;
        h.cut         = 0;
        return h;
    endfunction

    // Lay out the header words, fill in a correct checksum (or a damaged one)
    // and send the words in wire order. Only the start word carries frame_bytes;
    // the upper half of tdata on the other words is random and must be ignored.
    task automatic send_packet(input t_hdr h);
        logic [15:0] w [MAX_WORDS];
        logic [31:0] acc;
        int          n;
        int          i;
        for (i = 0; i < MAX_WORDS; i++)
            w[i] = 16'($urandom_range(65535));
        w[ipv4rx_pkg::W_VER_IHL][15:8] = {h.ver, h.ihl};
        w[ipv4rx_pkg::W_TOT_LEN]       = h.tot_len;
        w[ipv4rx_pkg::W_FRAG]          = h.frag;
        w[ipv4rx_pkg::W_TTL_PROTO]     = {h.ttl, h.proto};
        w[ipv4rx_pkg::W_DST_HI]        = h.dest[31:16];
        w[ipv4rx_pkg::W_DST_LO]        = h.dest[15:0];
        acc = 0;
        for (i = 0; i < 2 * int'(h.ihl); i++)
            if (i != CSUM_WORD)
                acc += 32'(w[i]);
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        w[CSUM_WORD] = ~acc[15:0];
        // A single flipped bit can never leave the sum at all ones.
        if (h.bad_sum)
            w[CSUM_WORD] = w[CSUM_WORD] ^ (16'd1 << $urandom_range(15));
        n = (h.ihl < ipv4rx_pkg::MIN_IHL) ? 10 : 2 * int'(h.ihl);
        if (h.cut > 0 && h.cut < n)
            n = h.cut;
        for (i = 0; i < n; i++)
            send_word(w[i], i == 0,
                      (i == 0) ? h.frame_bytes : 16'($urandom_range(65535)));
    endtask

    // Words without a start flag while the block is idle; they must give nothing.
    task automatic send_noise(input int n);
        repeat (n)
            send_word(16'($urandom_range(65535)), 1'b0, 16'($urandom_range(65535)));
    endtask

    // Directed cases: every verdict, the field extremes and the special cases.
    task automatic run_directed();
        t_hdr h;
        h = base_hdr(100);
        send_packet(h);
        // Longest header and largest lengths.
        h = base_hdr(65535);
        h.ihl = 4'd15;
        h.proto = ipv4rx_pkg::PROTO_TCP;
        h.frame_bytes = 16'hffff;
        send_packet(h);
        h = base_hdr(60);
        h.ihl = 4'd6;
        h.proto = ipv4rx_pkg::PROTO_ICMP;
        send_packet(h);
        h = base_hdr(40);
        h.proto = 8'hff;
        send_packet(h);
        h = base_hdr(20);
        h.proto = 8'h00;
        h.frame_bytes = 16'd20;
        send_packet(h);
        // Frames too short to hold any header, at both ends of that range.
        send_word(16'hffff, 1'b1, 16'd19);
        send_word(16'h0000, 1'b1, 16'd0);
        h = base_hdr(80);
        h.ver = 4'd6;
        send_packet(h);
        h = base_hdr(80);
        h.ver = 4'd15;
        send_packet(h);
        // More fragments, a fragment offset, DF alone (accepted) and every flag bit.
        h = base_hdr(80);
        h.frag = 16'h2000;
        send_packet(h);
        h = base_hdr(80);
        h.frag = 16'h1fff;
        send_packet(h);
        h = base_hdr(80);
        h.frag = 16'h4000;
        send_packet(h);
        h = base_hdr(80);
        h.frag = 16'hffff;
        send_packet(h);
        // Advertised length one byte longer than the frame.
        h = base_hdr(200);
        h.frame_bytes = 16'd199;
        send_packet(h);
        h = base_hdr(80);
        h.ihl = 4'd4;
        send_packet(h);
        h = base_hdr(80);
        h.ihl = 4'd0;
        send_packet(h);
        // Destination: foreign, broadcast and zero.
        h = base_hdr(80);
        h.dest = 32'h0a00_0001;
        send_packet(h);
        h = base_hdr(80);
        h.dest = ipv4rx_pkg::ADDR_BCAST;
        send_packet(h);
        h = base_hdr(80);
        h.dest = ipv4rx_pkg::ADDR_ZERO;
        send_packet(h);
        h = base_hdr(80);
        h.ttl = ipv4rx_pkg::TTL_EXPIRING;
        send_packet(h);
        h = base_hdr(80);
        h.ttl = 8'd0;
        send_packet(h);
        h = base_hdr(80);
        h.bad_sum = 1'b1;
        send_packet(h);
        // Several checks fail at once: the version must win.
        h = base_hdr(80);
        h.ver = 4'd5;
        h.ttl = ipv4rx_pkg::TTL_EXPIRING;
        h.bad_sum = 1'b1;
        send_packet(h);
        // Restart in mid-header, then idle words that must be dropped.
        h = base_hdr(80);
        h.cut = 5;
        send_packet(h);
        h = base_hdr(90);
        send_packet(h);
        send_noise(3);
    endtask

    // One random packet: mostly well-formed headers with random content, the
    // rest broken in one check, too short, cut short or plain noise.
    task automatic rand_packet();
        t_hdr h;
        int   pick;
        if ($urandom_range(9) == 0)
            h = base_hdr(int'($urandom_range(20, 65535)));
        else
            h = base_hdr(int'($urandom_range(20, 1500)));
        if ($urandom_range(9) < 3)
            h.ihl = 4'($urandom_range(6, 15));
        pick = int'($urandom_range(9));
        if (pick >= 9)
            h.proto = 8'($urandom_range(255));
        else if (pick >= 7)
            h.proto = ipv4rx_pkg::PROTO_ICMP;
        else if (pick >= 5)
            h.proto = ipv4rx_pkg::PROTO_TCP;
        pick = int'($urandom_range(9));
        if (pick == 8)
            h.dest = ipv4rx_pkg::ADDR_BCAST;
        else if (pick == 9)
            h.dest = ipv4rx_pkg::ADDR_ZERO;
        if ($urandom_range(3) == 0)
            h.frag = 16'h4000;

        pick = int'($urandom_range(99));
        if (pick < 5) begin
            h.ver = 4'($urandom_range(15));
        end else if (pick < 10) begin
            h.frag = 16'($urandom_range(1, 65535));
        end else if (pick < 15) begin
            h.tot_len     = 16'($urandom_range(21, 65535));
            h.frame_bytes = 16'($urandom_range(20, int'(h.tot_len) - 1));
        end else if (pick < 19) begin
            h.ihl = 4'($urandom_range(4));
        end else if (pick < 24) begin
            h.dest = $urandom;
        end else if (pick < 28) begin
            h.ttl = ipv4rx_pkg::TTL_EXPIRING;
        end else if (pick < 33) begin
            h.bad_sum = 1'b1;
        end else if (pick < 38) begin
            send_word(16'($urandom_range(65535)), 1'b1, 16'($urandom_range(19)));
            return;
        end else if (pick < 43) begin
            h.cut = int'($urandom_range(1, 9));
        end else if (pick < 47) begin
            send_noise(int'($urandom_range(1, 4)));
            return;
        end
        send_packet(h);
        // Now and then hold the sender until every verdict has come back.
        if ($urandom_range(11) == 0)
            drain();
    endtask

    // Main sequence: reset, directed cases, then four random phases with their own
    // address and their own idle pattern, each started with the block drained.
    initial begin
        int          p;
        int          k;
        int          send_pct [4];
        int          recv_pct [4];
        logic [31:0] addr_set [4];
        send_pct = '{0, 64, 0, 8};
        recv_pct = '{0, 0, 64, 8};
        addr_set = '{ipv4rx_pkg::ADDR_ZERO, ipv4rx_pkg::ADDR_BCAST, $urandom, $urandom};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_local(32'hc0a8_0a02);
        run_directed();

        for (p = 0; p < 4; p++) begin
            drain();
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            write_local(addr_set[p]);
            for (k = 0; k < PKTS_PER_PHASE; k++)
                rand_packet();
        end
        drain();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
